[hw/rtl/msq_pkg.sv]
// ----------------------------------------------------------------------------
// msq_pkg
// Types, constants and the segment table of the marching-squares cell
// segment generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int COL_W     = 10;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int DIFF_W    = 16;                 // |a - b| of two samples
  localparam int PROD_W    = STEP_W + DIFF_W;    // step * numerator
  localparam int MUL_W     = COL_W + 1 + STEP_W; // (col + 1) * step
  localparam int BASE_W    = MUL_W + 1;          // signed mesh coordinate
  localparam int OFF_W     = 32;                 // quotient, below 2^31
  localparam int LANES     = 4;
  localparam int DIV_STEP  = 4;                  // quotient bits per stage
  localparam int DIV_STAGES = OFF_W / DIV_STEP;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd4;
  localparam logic [STEP_W-1:0]    STEP_RESET   = 31'd65536;

  localparam logic [3:0] CORNER_BL = 4'b0001;
  localparam logic [3:0] CORNER_BR = 4'b0010;
  localparam logic [3:0] CORNER_TR = 4'b0100;
  localparam logic [3:0] CORNER_TL = 4'b1000;
  localparam logic [3:0] CASE_NONE = 4'b0000;
  localparam logic [3:0] CASE_ALL  = CORNER_BL | CORNER_BR | CORNER_TR | CORNER_TL;
  localparam logic [3:0] CASE_SADDLE_A = CORNER_BR | CORNER_TL;
  localparam logic [3:0] CASE_SADDLE_B = CORNER_BL | CORNER_TR;

  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_BELOW = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_ABOVE = 2'd3;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_TOP    = 2'd3
  } edge_t;

  typedef struct packed {
    logic [COL_W-1:0]           cell_col;
    logic [COL_W-1:0]           cell_row;
    logic signed [SAMPLE_W-1:0] value_bottom_left;
    logic signed [SAMPLE_W-1:0] value_bottom_right;
    logic signed [SAMPLE_W-1:0] value_top_right;
    logic signed [SAMPLE_W-1:0] value_top_left;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]          seg_col;
    logic [COL_W-1:0]          seg_row;
    logic [3:0]                case_code;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [1:0]                neighbour_first;
    logic [1:0]                neighbour_second;
    logic                      last_segment;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] level;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic [STEP_W-1:0]          step_x;
    logic [STEP_W-1:0]          step_y;
  } cfg_t;

  // one edge's division job: round(p / d), forced to zero when d is zero
  typedef struct packed {
    logic [PROD_W-1:0] p;
    logic [DIFF_W-1:0] d;
    logic              zero;
  } lane_t;

  // cell data that rides alongside the divider
  typedef struct packed {
    logic [COL_W-1:0]         col;
    logic [COL_W-1:0]         row;
    logic [3:0]               code;
    logic signed [BASE_W-1:0] x0;
    logic signed [BASE_W-1:0] x1;
    logic signed [BASE_W-1:0] y0;
    logic signed [BASE_W-1:0] y1;
  } side_t;

  typedef struct packed {
    logic       valid;
    logic       two;
    edge_t      a0;
    edge_t      b0;
    logic [1:0] f0;
    logic [1:0] s0;
    edge_t      a1;
    edge_t      b1;
    logic [1:0] f1;
    logic [1:0] s1;
  } seg_plan_t;

  function automatic seg_plan_t seg_plan(logic [3:0] code);
    seg_plan_t p;
    p.valid = 1'b1;
    p.two   = 1'b0;
    p.a0 = EDGE_LEFT;
    p.b0 = EDGE_BOTTOM;
    p.f0 = NB_LEFT;
    p.s0 = NB_BELOW;
    p.a1 = EDGE_TOP;
    p.b1 = EDGE_RIGHT;
    p.f1 = NB_ABOVE;
    p.s1 = NB_RIGHT;
    case (code) inside
      CORNER_BL, ~CORNER_BL: begin
        p.a0 = EDGE_LEFT;   p.b0 = EDGE_BOTTOM; p.f0 = NB_LEFT;  p.s0 = NB_BELOW;
      end
      CORNER_BR, ~CORNER_BR: begin
        p.a0 = EDGE_BOTTOM; p.b0 = EDGE_RIGHT;  p.f0 = NB_BELOW; p.s0 = NB_RIGHT;
      end
      CORNER_TL, ~CORNER_TL: begin
        p.a0 = EDGE_LEFT;   p.b0 = EDGE_TOP;    p.f0 = NB_LEFT;  p.s0 = NB_ABOVE;
      end
      CORNER_TR, ~CORNER_TR: begin
        p.a0 = EDGE_TOP;    p.b0 = EDGE_RIGHT;  p.f0 = NB_RIGHT; p.s0 = NB_ABOVE;
      end
      (CORNER_BL | CORNER_BR), (CORNER_TR | CORNER_TL): begin
        p.a0 = EDGE_LEFT;   p.b0 = EDGE_RIGHT;  p.f0 = NB_LEFT;  p.s0 = NB_RIGHT;
      end
      (CORNER_BL | CORNER_TL), (CORNER_BR | CORNER_TR): begin
        p.a0 = EDGE_TOP;    p.b0 = EDGE_BOTTOM; p.f0 = NB_BELOW; p.s0 = NB_ABOVE;
      end
      CASE_SADDLE_A: begin
        p.two = 1'b1;
        p.a0 = EDGE_LEFT;   p.b0 = EDGE_BOTTOM; p.f0 = NB_LEFT;  p.s0 = NB_BELOW;
        p.a1 = EDGE_TOP;    p.b1 = EDGE_RIGHT;  p.f1 = NB_ABOVE; p.s1 = NB_RIGHT;
      end
      CASE_SADDLE_B: begin
        p.two = 1'b1;
        p.a0 = EDGE_LEFT;   p.b0 = EDGE_TOP;    p.f0 = NB_ABOVE; p.s0 = NB_LEFT;
        p.a1 = EDGE_BOTTOM; p.b1 = EDGE_RIGHT;  p.f1 = NB_RIGHT; p.s1 = NB_BELOW;
      end
      default: p.valid = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/msq_front.sv]
// ----------------------------------------------------------------------------
// msq_front
// Two stages: corner classification, edge differences and mesh products,
// then the step * numerator products and the mesh corner coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_front import msq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cfg_t            cfg,
  input  logic            in_vld,
  input  in_item_t        in_item,
  output logic            out_vld,
  output lane_t [LANES-1:0] out_lane,
  output side_t           out_side
);

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [SAMPLE_W-1:0] a,
                                                 logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] t;
    logic [SAMPLE_W:0]        m;
    t = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    m = t[SAMPLE_W] ? (~t + 1'b1) : t;
    return m[DIFF_W-1:0];
  endfunction

  logic                          s1_vld_r;
  logic [DIFF_W-1:0]             s1_un_r [LANES];
  logic [DIFF_W-1:0]             s1_ud_r [LANES];
  logic [3:0]                    s1_code_r;
  logic [COL_W-1:0]              s1_col_r, s1_row_r;
  logic [MUL_W-1:0]              s1_mx0_r, s1_mx1_r, s1_my0_r, s1_my1_r;

  logic [DIFF_W-1:0]             un_nxt [LANES];
  logic [DIFF_W-1:0]             ud_nxt [LANES];
  logic [DIFF_W-1:0]             n_raw  [LANES];
  logic signed [SAMPLE_W-1:0]    va [LANES];
  logic signed [SAMPLE_W-1:0]    vb [LANES];
  logic [3:0]                    code_nxt;
  logic [COL_W:0]                colp1, rowp1;

  logic                          s2_vld_r;
  lane_t [LANES-1:0]             s2_lane_r;
  side_t                         s2_side_r;
  lane_t [LANES-1:0]             lane_nxt;

  always_comb begin
    code_nxt = CASE_NONE;
    if (in_item.value_bottom_left  > cfg.level) code_nxt = code_nxt | CORNER_BL;
    if (in_item.value_bottom_right > cfg.level) code_nxt = code_nxt | CORNER_BR;
    if (in_item.value_top_right    > cfg.level) code_nxt = code_nxt | CORNER_TR;
    if (in_item.value_top_left     > cfg.level) code_nxt = code_nxt | CORNER_TL;

    va[EDGE_LEFT]   = in_item.value_bottom_left;
    vb[EDGE_LEFT]   = in_item.value_top_left;
    va[EDGE_BOTTOM] = in_item.value_bottom_left;
    vb[EDGE_BOTTOM] = in_item.value_bottom_right;
    va[EDGE_RIGHT]  = in_item.value_bottom_right;
    vb[EDGE_RIGHT]  = in_item.value_top_right;
    va[EDGE_TOP]    = in_item.value_top_left;
    vb[EDGE_TOP]    = in_item.value_top_right;

    for (int k = 0; k < LANES; k++) begin
      n_raw[k]  = abs_diff(cfg.level, va[k]);
      ud_nxt[k] = abs_diff(vb[k], va[k]);
      // clamp so the fraction never exceeds one step
      un_nxt[k] = (n_raw[k] > ud_nxt[k]) ? ud_nxt[k] : n_raw[k];
    end

    colp1 = {1'b0, in_item.cell_col} + 1'b1;
    rowp1 = {1'b0, in_item.cell_row} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        s1_un_r[k] <= un_nxt[k];
        s1_ud_r[k] <= ud_nxt[k];
      end
      s1_code_r <= code_nxt;
      s1_col_r  <= in_item.cell_col;
      s1_row_r  <= in_item.cell_row;
      s1_mx0_r  <= MUL_W'(in_item.cell_col) * MUL_W'(cfg.step_x);
      s1_mx1_r  <= MUL_W'(colp1) * MUL_W'(cfg.step_x);
      s1_my0_r  <= MUL_W'(in_item.cell_row) * MUL_W'(cfg.step_y);
      s1_my1_r  <= MUL_W'(rowp1) * MUL_W'(cfg.step_y);
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (k == EDGE_LEFT || k == EDGE_RIGHT) begin
        lane_nxt[k].p = PROD_W'(cfg.step_y) * PROD_W'(s1_un_r[k]);
      end else begin
        lane_nxt[k].p = PROD_W'(cfg.step_x) * PROD_W'(s1_un_r[k]);
      end
      lane_nxt[k].d    = s1_ud_r[k];
      lane_nxt[k].zero = (s1_ud_r[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lane_r      <= lane_nxt;
      s2_side_r.col  <= s1_col_r;
      s2_side_r.row  <= s1_row_r;
      s2_side_r.code <= s1_code_r;
      s2_side_r.x0 <= {{(BASE_W-COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x}
                      + $signed({1'b0, s1_mx0_r});
      s2_side_r.x1 <= {{(BASE_W-COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x}
                      + $signed({1'b0, s1_mx1_r});
      s2_side_r.y0 <= {{(BASE_W-COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y}
                      + $signed({1'b0, s1_my0_r});
      s2_side_r.y1 <= {{(BASE_W-COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y}
                      + $signed({1'b0, s1_my1_r});
    end
  end

  assign out_vld  = s2_vld_r;
  assign out_lane = s2_lane_r;
  assign out_side = s2_side_r;

endmodule

`default_nettype wire

[hw/rtl/msq_div.sv]
// ----------------------------------------------------------------------------
// msq_div
// Pipelined restoring divider, one lane per cell edge, side by side. Each of
// the DIV_STAGES stages retires DIV_STEP quotient bits; a last stage rounds half up.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_div import msq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  lane_t [LANES-1:0]         in_lane,
  input  side_t                     in_side,
  output logic                      out_vld,
  output logic [LANES-1:0][OFF_W-1:0] out_off,
  output side_t                     out_side
);

  typedef struct packed {
    logic [DIFF_W-1:0] r;
    logic [OFF_W-1:0]  q;
    logic [OFF_W-1:0]  p;   // dividend bits not yet shifted in
    logic [DIFF_W-1:0] d;
    logic              zero;
  } dlane_t;

  function automatic dlane_t div_step(dlane_t a);
    dlane_t            b;
    logic [DIFF_W:0]   t;
    logic [DIFF_W:0]   diff;
    b = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      t   = {b.r, b.p[OFF_W-1]};
      b.p = {b.p[OFF_W-2:0], 1'b0};
      diff = t - {1'b0, b.d};
      if (t >= {1'b0, b.d}) begin
        b.r = diff[DIFF_W-1:0];
        b.q = {b.q[OFF_W-2:0], 1'b1};
      end else begin
        b.r = t[DIFF_W-1:0];
        b.q = {b.q[OFF_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  dlane_t                    st_r   [DIV_STAGES][LANES];
  dlane_t                    st_nxt [DIV_STAGES][LANES];
  dlane_t                    init   [LANES];
  logic [DIV_STAGES-1:0]     vld_r;
  side_t                     side_r [DIV_STAGES];
  logic                      rnd_vld_r;
  logic [LANES-1:0][OFF_W-1:0] rnd_off_r;
  side_t                     rnd_side_r;
  logic [LANES-1:0][OFF_W-1:0] rnd_nxt;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      // the quotient stays below 2^31, so the top bits already sit below d
      init[k].r    = {1'b0, in_lane[k].p[PROD_W-1:OFF_W]};
      init[k].p    = in_lane[k].p[OFF_W-1:0];
      init[k].q    = '0;
      init[k].d    = in_lane[k].d;
      init[k].zero = in_lane[k].zero;
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int k = 0; k < LANES; k++) begin
        st_nxt[s][k] = div_step((s == 0) ? init[k] : st_r[(s == 0) ? 0 : s - 1][k]);
      end
    end
    for (int k = 0; k < LANES; k++) begin
      if (st_r[DIV_STAGES-1][k].zero) begin
        rnd_nxt[k] = '0;
      end else begin
        rnd_nxt[k] = st_r[DIV_STAGES-1][k].q
                   + OFF_W'({st_r[DIV_STAGES-1][k].r, 1'b0} >= {1'b0, st_r[DIV_STAGES-1][k].d});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rnd_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[DIV_STAGES-2:0], in_vld};
      rnd_vld_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        for (int k = 0; k < LANES; k++) begin
          st_r[s][k] <= st_nxt[s][k];
        end
        side_r[s] <= (s == 0) ? in_side : side_r[(s == 0) ? 0 : s - 1];
      end
      rnd_off_r  <= rnd_nxt;
      rnd_side_r <= side_r[DIV_STAGES-1];
    end
  end

  assign out_vld  = rnd_vld_r;
  assign out_off  = rnd_off_r;
  assign out_side = rnd_side_r;

endmodule

`default_nettype wire

[hw/rtl/msq_emit.sv]
// ----------------------------------------------------------------------------
// msq_emit
// Places the edge points, saturates them and plays out one or two segment
// beats per cell from the output register. Drives the pipeline advance.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_emit import msq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [LANES-1:0][OFF_W-1:0] in_off,
  input  side_t                       in_side,
  output logic                        adv,
  output logic                        out_valid,
  input  logic                        out_ready,
  output out_item_t                   out_item
);

  function automatic logic [COORD_W-1:0] sat32(logic signed [BASE_W-1:0] v);
    logic signed [BASE_W-1:0] hi, lo;
    hi = {{(BASE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = {{(BASE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  logic signed [BASE_W-1:0] off_s [LANES];
  logic [COORD_W-1:0]       px_nxt [LANES];
  logic [COORD_W-1:0]       py_nxt [LANES];
  seg_plan_t                plan_nxt;

  logic                     vld_r;
  logic                     idx_r;
  seg_plan_t                plan_r;
  logic [COORD_W-1:0]       px_r [LANES];
  logic [COORD_W-1:0]       py_r [LANES];
  logic [COL_W-1:0]         col_r, row_r;
  logic [3:0]               code_r;
  logic                     last;
  edge_t                    ea, eb;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      off_s[k] = $signed({{(BASE_W-OFF_W){1'b0}}, in_off[k]});
    end
    px_nxt[EDGE_LEFT]   = sat32(in_side.x0);
    py_nxt[EDGE_LEFT]   = sat32(in_side.y0 + off_s[EDGE_LEFT]);
    px_nxt[EDGE_BOTTOM] = sat32(in_side.x0 + off_s[EDGE_BOTTOM]);
    py_nxt[EDGE_BOTTOM] = sat32(in_side.y0);
    px_nxt[EDGE_RIGHT]  = sat32(in_side.x1);
    py_nxt[EDGE_RIGHT]  = sat32(in_side.y0 + off_s[EDGE_RIGHT]);
    px_nxt[EDGE_TOP]    = sat32(in_side.x0 + off_s[EDGE_TOP]);
    py_nxt[EDGE_TOP]    = sat32(in_side.y1);
    plan_nxt = seg_plan(in_side.code);
  end

  assign last = idx_r | ~plan_r.two;
  // advance when the output register is empty or its last beat leaves now
  assign adv  = ~vld_r | (out_ready & last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 1'b0;
    end else if (adv) begin
      // drop cells that produce no segment
      vld_r <= in_vld & plan_nxt.valid;
      idx_r <= 1'b0;
    end else if (out_ready) begin
      idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plan_r <= plan_nxt;
      col_r  <= in_side.col;
      row_r  <= in_side.row;
      code_r <= in_side.code;
      for (int k = 0; k < LANES; k++) begin
        px_r[k] <= px_nxt[k];
        py_r[k] <= py_nxt[k];
      end
    end
  end

  always_comb begin
    ea = idx_r ? plan_r.a1 : plan_r.a0;
    eb = idx_r ? plan_r.b1 : plan_r.b0;
    out_item.seg_col          = col_r;
    out_item.seg_row          = row_r;
    out_item.case_code        = code_r;
    out_item.start_x          = px_r[ea];
    out_item.start_y          = py_r[ea];
    out_item.end_x            = px_r[eb];
    out_item.end_y            = py_r[eb];
    out_item.neighbour_first  = idx_r ? plan_r.f1 : plan_r.f0;
    out_item.neighbour_second = idx_r ? plan_r.s1 : plan_r.s0;
    out_item.last_segment     = last;
  end

  assign out_valid = vld_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last_segment |=> out_valid && out_item.last_segment)
    else $error("first saddle beat not followed by its last beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_segment |->
      out_item.case_code == CASE_SADDLE_A || out_item.case_code == CASE_SADDLE_B)
    else $error("two segments from a non-saddle cell");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.case_code != CASE_NONE && out_item.case_code != CASE_ALL)
    else $error("segment emitted for an empty cell");

  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_valid)
    else $error("pipeline stalled with nothing to deliver");

endmodule

`default_nettype wire

[hw/rtl/marching_squares_cell_segments.sv]
// A cell passes the front stages, the divider stages, the rounding register and the
// output register; the second beat of a saddle cell follows once the first is taken.
// Throughput: one cell per cycle while out_ready is high; a saddle cell holds the
// output for both beats, as the single output register plays out one segment a cycle.
// Reset (synchronous, rst_n low) empties the pipeline and loads level 0,
// origins 0 and steps 1.0.
// ----------------------------------------------------------------------------
// marching_squares_cell_segments
// Marching-squares contour segments for one grid cell per input beat,
// with interpolated Q16.16 endpoints on a regular mesh.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_segments import msq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  cfg_t                        cfg_r;
  logic                        adv;
  logic                        fr_vld;
  lane_t [LANES-1:0]           fr_lane;
  side_t                       fr_side;
  logic                        dv_vld;
  logic [LANES-1:0][OFF_W-1:0] dv_off;
  side_t                       dv_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level    <= '0;
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.step_x   <= STEP_RESET;
      cfg_r.step_y   <= STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEVEL:    cfg_r.level    <= cfg_wdata[SAMPLE_W-1:0];
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_wdata[COORD_W-1:0];
        CFG_STEP_X:   cfg_r.step_x   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_Y:   cfg_r.step_y   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = adv;

  msq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cfg      (cfg_r),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .out_vld  (fr_vld),
    .out_lane (fr_lane),
    .out_side (fr_side)
  );

  msq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (fr_vld),
    .in_lane  (fr_lane),
    .in_side  (fr_side),
    .out_vld  (dv_vld),
    .out_off  (dv_off),
    .out_side (dv_side)
  );

  msq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (dv_vld),
    .in_off    (dv_off),
    .in_side   (dv_side),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[bench/marching_squares_cell_segments_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_checker
// Watches the cell and segment channels and the register port, predicts the
// contour segments of every accepted cell and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_segments_checker import msq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  output int                    errors,
  output int                    pending
);

  localparam int EXP_DEPTH = 256;

  cfg_t         regs;
  out_item_t    exp_mem [EXP_DEPTH];
  int           wr_cnt = 0;
  int           rd_cnt = 0;

  assign pending = wr_cnt - rd_cnt;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(step * min(|lvl - va|, |vb - va|) / |vb - va|), halves up; zero if vb == va
  function automatic longint interp(longint stp, longint va, longint vb, longint lvl);
    longint num, den, q, r;
    num = lvl - va;
    den = vb - va;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    if (den == 0) return 0;
    if (num > den) num = den;
    q = (stp * num) / den;
    r = (stp * num) % den;
    if (2 * r >= den) q++;
    return q;
  endfunction

  task automatic predict_segments(input in_item_t c);
    longint lvl, x0, y0, sx, sy, vbl, vbr, vtr, vtl;
    longint px[4], py[4];
    logic [3:0] code;
    edge_t ea[2], eb[2];
    logic [1:0] nf[2], ns[2];
    int n;
    out_item_t s;
    lvl = regs.level;
    sx = regs.step_x;
    sy = regs.step_y;
    vbl = c.value_bottom_left;
    vbr = c.value_bottom_right;
    vtr = c.value_top_right;
    vtl = c.value_top_left;
    x0 = longint'(regs.origin_x) + longint'(c.cell_col) * sx;
    y0 = longint'(regs.origin_y) + longint'(c.cell_row) * sy;
    code = {vtl > lvl, vtr > lvl, vbr > lvl, vbl > lvl};
    px[EDGE_LEFT] = x0;
    py[EDGE_LEFT] = y0 + interp(sy, vbl, vtl, lvl);
    px[EDGE_RIGHT] = x0 + sx;
    py[EDGE_RIGHT] = y0 + interp(sy, vbr, vtr, lvl);
    px[EDGE_BOTTOM] = x0 + interp(sx, vbl, vbr, lvl);
    py[EDGE_BOTTOM] = y0;
    px[EDGE_TOP] = x0 + interp(sx, vtl, vtr, lvl);
    py[EDGE_TOP] = y0 + sy;
    n = 1;
    case (code)
      CORNER_BL, ~CORNER_BL: begin
        ea[0] = EDGE_LEFT; eb[0] = EDGE_BOTTOM; nf[0] = NB_LEFT; ns[0] = NB_BELOW;
      end
      CORNER_BR, ~CORNER_BR: begin
        ea[0] = EDGE_BOTTOM; eb[0] = EDGE_RIGHT; nf[0] = NB_BELOW; ns[0] = NB_RIGHT;
      end
      CORNER_TL, ~CORNER_TL: begin
        ea[0] = EDGE_LEFT; eb[0] = EDGE_TOP; nf[0] = NB_LEFT; ns[0] = NB_ABOVE;
      end
      CORNER_TR, ~CORNER_TR: begin
        ea[0] = EDGE_TOP; eb[0] = EDGE_RIGHT; nf[0] = NB_RIGHT; ns[0] = NB_ABOVE;
      end
      (CORNER_BL | CORNER_BR), (CORNER_TR | CORNER_TL): begin
        ea[0] = EDGE_LEFT; eb[0] = EDGE_RIGHT; nf[0] = NB_LEFT; ns[0] = NB_RIGHT;
      end
      (CORNER_BL | CORNER_TL), (CORNER_BR | CORNER_TR): begin
        ea[0] = EDGE_TOP; eb[0] = EDGE_BOTTOM; nf[0] = NB_BELOW; ns[0] = NB_ABOVE;
      end
      CASE_SADDLE_A: begin
        ea[0] = EDGE_LEFT; eb[0] = EDGE_BOTTOM; nf[0] = NB_LEFT; ns[0] = NB_BELOW;
        ea[1] = EDGE_TOP; eb[1] = EDGE_RIGHT; nf[1] = NB_ABOVE; ns[1] = NB_RIGHT;
        n = 2;
      end
      CASE_SADDLE_B: begin
        ea[0] = EDGE_LEFT; eb[0] = EDGE_TOP; nf[0] = NB_ABOVE; ns[0] = NB_LEFT;
        ea[1] = EDGE_BOTTOM; eb[1] = EDGE_RIGHT; nf[1] = NB_RIGHT; ns[1] = NB_BELOW;
        n = 2;
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      s.seg_col = c.cell_col;
      s.seg_row = c.cell_row;
      s.case_code = code;
      s.start_x = 32'(clamp32(px[ea[k]]));
      s.start_y = 32'(clamp32(py[ea[k]]));
      s.end_x = 32'(clamp32(px[eb[k]]));
      s.end_y = 32'(clamp32(py[eb[k]]));
      s.neighbour_first = nf[k];
      s.neighbour_second = ns[k];
      s.last_segment = (k == n - 1);
      exp_mem[wr_cnt % EXP_DEPTH] = s;
      wr_cnt++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: segment %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare_segment(input out_item_t got);
    out_item_t want;
    if (wr_cnt == rd_cnt) begin
      $display("%0t: segment beat with nothing expected", $realtime);
      errors++;
      return;
    end
    want = exp_mem[rd_cnt % EXP_DEPTH];
    rd_cnt++;
    if (got.seg_col !== want.seg_col) report_mismatch("seg_col", got.seg_col, want.seg_col);
    if (got.seg_row !== want.seg_row) report_mismatch("seg_row", got.seg_row, want.seg_row);
    if (got.case_code !== want.case_code)
      report_mismatch("case_code", got.case_code, want.case_code);
    if (got.start_x !== want.start_x) report_mismatch("start_x", got.start_x, want.start_x);
    if (got.start_y !== want.start_y) report_mismatch("start_y", got.start_y, want.start_y);
    if (got.end_x !== want.end_x) report_mismatch("end_x", got.end_x, want.end_x);
    if (got.end_y !== want.end_y) report_mismatch("end_y", got.end_y, want.end_y);
    if (got.neighbour_first !== want.neighbour_first)
      report_mismatch("neighbour_first", got.neighbour_first, want.neighbour_first);
    if (got.neighbour_second !== want.neighbour_second)
      report_mismatch("neighbour_second", got.neighbour_second, want.neighbour_second);
    if (got.last_segment !== want.last_segment)
      report_mismatch("last_segment", got.last_segment, want.last_segment);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors = 0;
      wr_cnt = 0;
      rd_cnt = 0;
      regs.level <= '0;
      regs.origin_x <= '0;
      regs.origin_y <= '0;
      regs.step_x <= STEP_RESET;
      regs.step_y <= STEP_RESET;
    end else begin
      // registers change only while idle, so cells see the settled values
      if (in_valid && in_ready) predict_segments(in_item);
      if (out_valid && out_ready) compare_segment(out_item);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LEVEL:    regs.level <= cfg_wdata[SAMPLE_W-1:0];
          CFG_ORIGIN_X: regs.origin_x <= cfg_wdata;
          CFG_ORIGIN_Y: regs.origin_y <= cfg_wdata;
          CFG_STEP_X:   regs.step_x <= cfg_wdata[STEP_W-1:0];
          CFG_STEP_Y:   regs.step_y <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[bench/marching_squares_cell_segments_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_tb
// Drives directed and random grid cells through the segment generator under
// several register settings and idle patterns; the checker compares segments.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_segments_tb import msq_pkg::*; ();

  localparam int LATENCY = 11;
  localparam longint CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  int                    errors;
  int                    pending;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  longint cycles;

  marching_squares_cell_segments dut (.*);

  marching_squares_cell_segments_checker chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .errors, .pending
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("marching_squares_cell_segments_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // drop valid, then wait until every expected segment has come
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high after the beat; the next cell or drain decides what follows
  task automatic send_cell(input in_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] lvl);
    case ($urandom_range(5))
      0: return lvl;
      1: return lvl + 16'd1;
      2: return lvl - 16'd1;
      3: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_cell(input logic [15:0] lvl);
    in_item_t c;
    c.cell_col = ($urandom_range(9) == 0) ? 10'h3ff : 10'($urandom);
    c.cell_row = ($urandom_range(9) == 0) ? 10'h3ff : 10'($urandom);
    c.value_bottom_left = pick_sample(lvl);
    c.value_bottom_right = pick_sample(lvl);
    c.value_top_right = pick_sample(lvl);
    c.value_top_left = pick_sample(lvl);
    return c;
  endfunction

  task automatic set_regs(input logic [15:0] lvl, input logic [31:0] ox, input logic [31:0] oy,
                          input logic [30:0] sx, input logic [30:0] sy);
    write_reg(CFG_LEVEL, {16'h0, lvl});
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_STEP_X, {1'b0, sx});
    write_reg(CFG_STEP_Y, {1'b0, sy});
  endtask

  task automatic random_phase(input int count, input logic [15:0] lvl);
    for (int i = 0; i < count; i++) send_cell(random_cell(lvl));
    drain();
  endtask

  initial begin
    in_item_t c;
    cycles = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all sixteen codes at reset settings, extremes of the fields
    for (int code = 0; code < 16; code++) begin
      c.cell_col = code[0] ? 10'h3ff : 10'd0;
      c.cell_row = code[1] ? 10'h3ff : 10'd0;
      c.value_bottom_left  = code[0] ? 16'sh7fff : -16'sd32768;
      c.value_bottom_right = code[1] ? 16'sd1 : 16'sd0;
      c.value_top_right    = code[2] ? 16'sd300 : -16'sd7;
      c.value_top_left     = code[3] ? 16'sd9 : 16'sh8000;
      send_cell(c);
    end
    // equal corners on the edges that are not crossed, zero denominator in their lanes
    c = '0;
    c.value_bottom_left = 16'sd5;
    send_cell(c);
    drain();

    // saturation: huge steps and origins at both limits
    set_regs(16'h8000, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff);
    for (int i = 0; i < 4; i++) send_cell(random_cell(16'h8000));
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;
    set_regs(16'h7fff, 32'h80000000, 32'h7fffffff, 31'd1, 31'd1);
    random_phase(100, 16'h7ffe);

    send_idle_pct = 64; recv_stall_pct = 0;
    set_regs(16'h0000, 32'h00000000, 32'h00000000, 31'd65536, 31'd65536);
    random_phase(400, 16'h0000);

    send_idle_pct = 0;  recv_stall_pct = 64;
    set_regs(16'hfc18, 32'hfff00000, 32'h00123456, 31'd98304, 31'd12345);
    random_phase(400, 16'hfc18);

    send_idle_pct = 14; recv_stall_pct = 14;
    set_regs(16'($urandom), $urandom, $urandom, 31'($urandom_range(2000000, 1)),
             31'($urandom));
    random_phase(400, 16'h1234);

    // long receiver hold-off while cells keep coming
    send_idle_pct = 0;  recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) send_cell(random_cell(16'h1234));
    join
    drain();

    send_idle_pct = 30; recv_stall_pct = 30;
    set_regs(16'h0000, 32'h0, 32'h0, 31'h40000000, 31'd3);
    random_phase(300, 16'h0000);

    if (errors == 0) begin
      $display("marching_squares_cell_segments_tb passed");
    end else begin
      $display("marching_squares_cell_segments_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
